/* hdl/tpag_pkg.sv */
`timescale 1ns / 1ps

package tpag_pkg;

  // Tensor geometry.
  localparam int MAX_DIMS  = 4;
  localparam int DIM_WIDTH = 16;

  // Packed register field layout.
  localparam int FIELD_W    = 16;
  localparam int PERM_W     = 2;
  localparam int PERM_REG_W = 8;
  localparam int NDIM_W     = 3;

  // Datapath widths.
  localparam int ELEM_W = 16;
  localparam int OFS_W  = 32;
  localparam int PROD_W = DIM_WIDTH + FIELD_W;

  // Configuration port.
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_SEL_W   = ADDR_W - REG_SEL_LSB;

  localparam logic [REG_SEL_W-1:0] REG_NUM_DIMS    = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_DIM_SIZES   = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_IN_STRIDES  = REG_SEL_W'(2);
  localparam logic [REG_SEL_W-1:0] REG_OUT_STRIDES = REG_SEL_W'(3);
  localparam logic [REG_SEL_W-1:0] REG_PERMUTATION = REG_SEL_W'(4);

  localparam logic [NDIM_W-1:0]     NUM_DIMS_RST  = NDIM_W'(1);
  localparam logic [DATA_W-1:0]     DIM_SIZES_RST = DATA_W'(1);
  localparam logic [PERM_REG_W-1:0] PERM_RST      = PERM_REG_W'(228);

  typedef logic [DIM_WIDTH-1:0] coord_t;
  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [OFS_W-1:0]     ofs_t;

  typedef struct packed {
    logic [NDIM_W-1:0]     num_dims;
    logic [DATA_W-1:0]     dim_sizes;
    logic [DATA_W-1:0]     in_strides;
    logic [DATA_W-1:0]     out_strides;
    logic [PERM_REG_W-1:0] permutation;
  } cfg_t;

  // Snapshot of one element after the coordinate stage.
  typedef struct packed {
    logic [ELEM_W-1:0]         elem;
    coord_t [MAX_DIMS-1:0]     cur;
    coord_t [MAX_DIMS-1:0]     pc;
    logic                      last;
  } s1_t;

  typedef struct packed {
    logic wrap;
    logic coord_zero;
    logic unused_zero;
  } odo_status_t;

  // Zero acts as one dimension, anything above the maximum is clamped.
  function automatic logic [NDIM_W-1:0] dims_in_use(input logic [NDIM_W-1:0] nd);
    logic [NDIM_W-1:0] n;
    n = nd;
    if (n == '0) begin
      n = NDIM_W'(1);
    end
    if (n > NDIM_W'(MAX_DIMS)) begin
      n = NDIM_W'(MAX_DIMS);
    end
    return n;
  endfunction

endpackage

/* hdl/tpag_ifs.sv */
`timescale 1ns / 1ps

interface tpag_in_if;
  import tpag_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface tpag_out_if;
  import tpag_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element_out;
  logic [OFS_W-1:0]  out_offset;
  logic [OFS_W-1:0]  in_offset;
  logic              last;

  modport source (output valid, output element_out, output out_offset, output in_offset,
                  output last, input ready);
  modport sink   (input valid, input element_out, input out_offset, input in_offset,
                  input last, output ready);
endinterface

/* hdl/tpag_cfg.sv */
`timescale 1ns / 1ps

module tpag_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpag_pkg::ADDR_W-1:0] paddr,
  input  logic [tpag_pkg::DATA_W-1:0] pwdata,
  output logic [tpag_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tpag_pkg::cfg_t              cfg
);
  import tpag_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:REG_SEL_LSB];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_dims    <= NUM_DIMS_RST;
      cfg_r.dim_sizes   <= DIM_SIZES_RST;
      cfg_r.in_strides  <= '0;
      cfg_r.out_strides <= '0;
      cfg_r.permutation <= PERM_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NUM_DIMS:    cfg_r.num_dims    <= pwdata[NDIM_W-1:0];
        REG_DIM_SIZES:   cfg_r.dim_sizes   <= pwdata;
        REG_IN_STRIDES:  cfg_r.in_strides  <= pwdata;
        REG_OUT_STRIDES: cfg_r.out_strides <= pwdata;
        REG_PERMUTATION: cfg_r.permutation <= pwdata[PERM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NUM_DIMS:    prdata = DATA_W'(cfg_r.num_dims);
      REG_DIM_SIZES:   prdata = cfg_r.dim_sizes;
      REG_IN_STRIDES:  prdata = cfg_r.in_strides;
      REG_OUT_STRIDES: prdata = cfg_r.out_strides;
      REG_PERMUTATION: prdata = DATA_W'(cfg_r.permutation);
      default:         prdata = '0;
    endcase
  end

endmodule

/* hdl/tpag_odometer.sv */
`timescale 1ns / 1ps

module tpag_odometer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tpag_pkg::cfg_t        cfg,
  tpag_in_if.sink               in_stream,
  output logic                  link_valid,
  input  logic                  link_ready,
  output tpag_pkg::s1_t         link_data,
  output tpag_pkg::odo_status_t odo_st
);
  import tpag_pkg::*;

  coord_t [MAX_DIMS-1:0] coord_r;
  coord_t [MAX_DIMS-1:0] coord_nxt;
  coord_t [MAX_DIMS-1:0] cur;
  coord_t [MAX_DIMS-1:0] pc;
  coord_t [MAX_DIMS-1:0] size_v;
  logic [MAX_DIMS-1:0]   in_use;
  logic [MAX_DIMS-1:0]   at_end;
  logic [NDIM_W-1:0]     n_dims;
  logic [PERM_W-1:0]     src;
  logic                  carry;
  logic                  last;
  logic                  unused_zero;
  logic                  s1_valid_r;
  s1_t                   s1_r;
  logic                  in_ready;
  logic                  take;

  always_comb begin
    n_dims      = dims_in_use(cfg.num_dims);
    unused_zero = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      in_use[i] = NDIM_W'(i) < n_dims;
      cur[i]    = in_use[i] ? coord_r[i] : '0;
      size_v[i] = cfg.dim_sizes[i*FIELD_W +: DIM_WIDTH];
      if (size_v[i] == '0) begin
        size_v[i] = coord_t'(1);
      end
      // A coordinate at or past its last index (size minus one) counts as the final index.
      at_end[i] = ({1'b0, cur[i]} + (DIM_WIDTH+1)'(1)) >= {1'b0, size_v[i]};
      if (!in_use[i] && coord_r[i] != '0) begin
        unused_zero = 1'b0;
      end
    end

    // Gather: output dimension i takes the coordinate of input dimension perm[i].
    for (int i = 0; i < MAX_DIMS; i++) begin
      src   = cfg.permutation[i*PERM_W +: PERM_W];
      pc[i] = '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
        if (in_use[i] && in_use[j] && src == PERM_W'(j)) begin
          pc[i] = cur[j];
        end
      end
    end

    last = &(at_end | ~in_use);

    // Odometer advance with dimension 0 fastest.
    carry = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (!in_use[i]) begin
        coord_nxt[i] = '0;
      end else if (carry) begin
        if (at_end[i]) begin
          coord_nxt[i] = '0;
        end else begin
          coord_nxt[i] = coord_t'(cur[i] + 1'b1);
          carry        = 1'b0;
        end
      end else begin
        coord_nxt[i] = cur[i];
      end
    end
  end

  assign in_ready        = !s1_valid_r || link_ready;
  assign take            = in_stream.valid && in_ready;
  assign in_stream.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      coord_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_stream.valid;
      end
      if (take) begin
        coord_r <= coord_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r.elem <= in_stream.element;
      s1_r.cur  <= cur;
      s1_r.pc   <= pc;
      s1_r.last <= last;
    end
  end

  assign link_valid = s1_valid_r;
  assign link_data  = s1_r;

  assign odo_st.wrap        = last;
  assign odo_st.coord_zero  = (coord_r == '0);
  assign odo_st.unused_zero = unused_zero;

endmodule

/* hdl/tpag_offset.sv */
`timescale 1ns / 1ps

module tpag_offset (
  input  logic           clk,
  input  logic           rst_n,
  input  tpag_pkg::cfg_t cfg,
  input  logic           link_valid,
  output logic           link_ready,
  input  tpag_pkg::s1_t  link_data,
  tpag_out_if.source     out_stream
);
  import tpag_pkg::*;

  logic                  s2_valid_r;
  logic [ELEM_W-1:0]     s2_elem_r;
  logic                  s2_last_r;
  ofs_t [MAX_DIMS-1:0]   prod_in_r;
  ofs_t [MAX_DIMS-1:0]   prod_out_r;
  ofs_t [MAX_DIMS-1:0]   prod_in_nxt;
  ofs_t [MAX_DIMS-1:0]   prod_out_nxt;
  logic [PROD_W-1:0]     mul_in;
  logic [PROD_W-1:0]     mul_out;

  logic                  out_valid_r;
  logic [ELEM_W-1:0]     out_elem_r;
  ofs_t                  out_ofs_r;
  ofs_t                  in_ofs_r;
  logic                  out_last_r;
  ofs_t                  sum_in;
  ofs_t                  sum_out;

  logic                  ld2;
  logic                  ld3;

  // Stage 2: one multiplier per dimension and per offset.
  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      mul_in          = PROD_W'(link_data.cur[i]) *
                        PROD_W'(cfg.in_strides[i*FIELD_W +: FIELD_W]);
      mul_out         = PROD_W'(link_data.pc[i]) *
                        PROD_W'(cfg.out_strides[i*FIELD_W +: FIELD_W]);
      prod_in_nxt[i]  = OFS_W'(mul_in);
      prod_out_nxt[i] = OFS_W'(mul_out);
    end
  end

  // Stage 3: the products are summed modulo 2^32.
  always_comb begin
    sum_in  = '0;
    sum_out = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      sum_in  = sum_in + prod_in_r[i];
      sum_out = sum_out + prod_out_r[i];
    end
  end

  assign ld3        = !out_valid_r || out_stream.ready;
  assign ld2        = !s2_valid_r || ld3;
  assign link_ready = ld2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld2) begin
        s2_valid_r <= link_valid;
      end
      if (ld3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && link_valid) begin
      s2_elem_r  <= link_data.elem;
      s2_last_r  <= link_data.last;
      prod_in_r  <= prod_in_nxt;
      prod_out_r <= prod_out_nxt;
    end
    if (ld3 && s2_valid_r) begin
      out_elem_r <= s2_elem_r;
      out_last_r <= s2_last_r;
      in_ofs_r   <= sum_in;
      out_ofs_r  <= sum_out;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.element_out = out_elem_r;
  assign out_stream.out_offset  = out_ofs_r;
  assign out_stream.in_offset   = in_ofs_r;
  assign out_stream.last        = out_last_r;

endmodule

/* hdl/tensor_permute_address_generator.sv */
`timescale 1ns / 1ps
// A request passes in order through the coordinate stage, the multiplier stage and
// the adder stage, whose output register holds the result until it is taken.
// Throughput: one request per cycle while results are taken; each stage has its own
// valid bit. Reset (rst_n low at a clock edge) empties the pipeline, clears the
// coordinate counter and loads the register defaults: one dimension of size one,
// zero strides and the identity permutation.

module tensor_permute_address_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  tpag_in_if.sink                     in_stream,
  tpag_out_if.source                  out_stream,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpag_pkg::ADDR_W-1:0] paddr,
  input  logic [tpag_pkg::DATA_W-1:0] pwdata,
  output logic [tpag_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tpag_pkg::*;

  // The configuration registers feed both stages directly, so no shadow copies are kept.
  // They must only be written while no request is in flight; the block does not enforce it.
  cfg_t        cfg;
  logic        link_valid;
  logic        link_ready;
  s1_t         link_data;
  odo_status_t odo_st;

  tpag_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The coordinate stage owns the odometer. When a request is accepted it snapshots
  // the current coordinate, the permuted coordinate and the last flag, and steps
  // the counter. The counter wraps to all zeros after the final element.
  tpag_odometer u_odometer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_stream  (in_stream),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .link_data  (link_data),
    .odo_st     (odo_st)
  );

  // The offset stages form the per-dimension products, then add them up and hold
  // the finished result in the output register until it is taken. Each stage
  // refills as soon as it is empty or its contents move on, so while a result waits at
  // the output, new requests still fill any empty stage ahead of it.
  tpag_offset u_offset (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .link_data  (link_data),
    .out_stream (out_stream)
  );

  // Accepting the final element of the tensor must bring the counter back to zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_stream.valid && in_stream.ready && odo_st.wrap) |=> odo_st.coord_zero)
    else $error("coordinate counter did not wrap to zero after the last element");

  // Dimensions that are not in use are cleared by every step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_stream.valid && in_stream.ready) |=> odo_st.unused_zero)
    else $error("unused dimension holds a nonzero coordinate after a step");

  // The input side only stalls when the coordinate stage is full and blocked.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_stream.ready |-> (link_valid && !link_ready))
    else $error("input stalled while the coordinate stage could advance");

  // A stalled coordinate stage keeps its request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (link_valid && !link_ready) |=> (link_valid && $stable(link_data)))
    else $error("coordinate stage dropped or changed a stalled request");

endmodule

/* test/tb_tensor_permute_address_generator.sv */
`timescale 1ns / 1ps

import tpag_pkg::*;

// One expected output request: the element and where it lands.
typedef struct {
  logic [ELEM_W-1:0] element;
  ofs_t              out_offset;
  ofs_t              in_offset;
  logic              last;
} placement_t;

// Mirrors the register file and the coordinate odometer, and queues the
// placement that each accepted element should produce.
class permute_scoreboard;
  logic [NDIM_W-1:0]     num_dims;
  logic [DATA_W-1:0]     dim_sizes;
  logic [DATA_W-1:0]     in_strides;
  logic [DATA_W-1:0]     out_strides;
  logic [PERM_REG_W-1:0] permutation;
  coord_t                coord [MAX_DIMS];
  placement_t            pending [$];
  int                    errors;
  int                    results;
  int                    tensor_ends;

  function new();
    num_dims    = NDIM_W'(1);
    dim_sizes   = DATA_W'(1);
    in_strides  = '0;
    out_strides = '0;
    permutation = PERM_REG_W'(228);
    foreach (coord[i]) coord[i] = '0;
    errors      = 0;
    results     = 0;
    tensor_ends = 0;
  endfunction

  function void write_register(logic [REG_SEL_W-1:0] idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_NUM_DIMS:    num_dims    = value[NDIM_W-1:0];
      REG_DIM_SIZES:   dim_sizes   = value;
      REG_IN_STRIDES:  in_strides  = value;
      REG_OUT_STRIDES: out_strides = value;
      REG_PERMUTATION: permutation = value[PERM_REG_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned active_dims();
    int unsigned n;
    n = 32'(num_dims);
    if (n == 0) n = 1;
    if (n > MAX_DIMS) n = MAX_DIMS;
    return n;
  endfunction

  // A size of zero counts as one.
  function int unsigned extent(int i);
    int unsigned s;
    s = 32'(dim_sizes[FIELD_W*i +: FIELD_W]);
    return (s == 0) ? 1 : s;
  endfunction

  function void note_request(logic [ELEM_W-1:0] element);
    int unsigned n;
    int unsigned src;
    int unsigned pc;
    int unsigned cur [MAX_DIMS];
    ofs_t        in_ofs;
    ofs_t        out_ofs;
    bit          is_last;
    bit          carry;
    placement_t  p;
    n = active_dims();
    for (int i = 0; i < MAX_DIMS; i++) cur[i] = (i < n) ? 32'(coord[i]) : 0;
    in_ofs  = '0;
    out_ofs = '0;
    is_last = 1'b1;
    carry   = 1'b1;
    for (int i = 0; i < n; i++) begin
      src = 32'(permutation[PERM_W*i +: PERM_W]);
      pc  = (src < n) ? cur[src] : 0;
      in_ofs  = in_ofs + ofs_t'(cur[i]) * ofs_t'(in_strides[FIELD_W*i +: FIELD_W]);
      out_ofs = out_ofs + ofs_t'(pc) * ofs_t'(out_strides[FIELD_W*i +: FIELD_W]);
      if (cur[i] + 1 < extent(i)) is_last = 1'b0;
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (i >= n) begin
        coord[i] = '0;
      end else if (carry) begin
        if (cur[i] + 1 >= extent(i)) begin
          coord[i] = '0;
        end else begin
          coord[i] = coord_t'(cur[i] + 1);
          carry    = 1'b0;
        end
      end
    end
    p.element    = element;
    p.out_offset = out_ofs;
    p.in_offset  = in_ofs;
    p.last       = is_last;
    pending.push_back(p);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  task check_result(logic [ELEM_W-1:0] element, ofs_t out_offset, ofs_t in_offset,
                    logic last);
    placement_t p;
    results++;
    if (last) tensor_ends++;
    if (pending.size() == 0) begin
      report("unexpected result, element", 32'(element), '0);
    end else begin
      p = pending.pop_front();
      if (element !== p.element) report("element_out", 32'(element), 32'(p.element));
      if (out_offset !== p.out_offset) report("out_offset", out_offset, p.out_offset);
      if (in_offset !== p.in_offset) report("in_offset", in_offset, p.in_offset);
      if (last !== p.last) report("last", 32'(last), 32'(p.last));
    end
  endtask
endclass

module tb_tensor_permute_address_generator;

  // Register indexes past the end of the map; writes there must be ignored.
  localparam logic [REG_SEL_W-1:0] REG_SPARE_FIRST = REG_SEL_W'(5);
  localparam int                   REG_SPARE_SPAN  = 3;

  // Cycle limit for the whole run, set far beyond what it needs.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_ELEMENTS = 700;
  localparam int IDLE_PERCENT    = 27;

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [ADDR_W-1:0]     cfg_paddr;
  logic [DATA_W-1:0]     cfg_pwdata;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  tpag_in_if  in_if ();
  tpag_out_if out_if ();

  tensor_permute_address_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready)
  );

  permute_scoreboard sb = new();

  // When set, neither side inserts idle cycles, so the pipeline runs full.
  bit steady = 1'b0;
  int cycles = 0;
  int settings = 0;
  int random_sent = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timeout guard. The cycle count also serves the summary.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               sb.pending.size());
      $display("tensor_permute_address_generator test failed");
      $finish;
    end
  end

  // The result side stalls at random, except during the steady stretch.
  always @(negedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Every result accepted at a rising edge is compared with the oldest
  // outstanding placement.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.element_out, out_if.out_offset, out_if.in_offset, out_if.last);
    end
  end

  // Offers one element, with random idle cycles ahead of it. Valid stays high
  // after acceptance so that back-to-back requests never drop it in between;
  // the caller or the next idle cycle lowers it at a later falling edge.
  task send_element(logic [ELEM_W-1:0] element);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.element <= element;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(element);
    @(negedge clk);
  endtask

  // Random elements, with the bit extremes mixed in now and then.
  task send_elements(int count);
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(15);
      if (pick == 0) send_element('0);
      else if (pick == 1) send_element('1);
      else send_element(ELEM_W'($urandom_range(65535)));
    end
  endtask

  // Stops the input and waits until every result has come back, so that the
  // registers are only touched while the block is idle.
  task drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Setup cycle, then access cycle held until pready. The bus is released at
  // a separate falling edge so that psel is never lowered and raised in the
  // same time step by two writes in a row.
  task cfg_write(logic [REG_SEL_W-1:0] idx, logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, {REG_SEL_LSB{1'b0}}};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_register(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Sets up a whole tensor shape in one go.
  task cfg_shape(logic [NDIM_W-1:0] nd, logic [DATA_W-1:0] sizes, logic [DATA_W-1:0] istr,
                 logic [DATA_W-1:0] ostr, logic [PERM_REG_W-1:0] perm);
    cfg_write(REG_NUM_DIMS, DATA_W'(nd));
    cfg_write(REG_DIM_SIZES, sizes);
    cfg_write(REG_IN_STRIDES, istr);
    cfg_write(REG_OUT_STRIDES, ostr);
    cfg_write(REG_PERMUTATION, DATA_W'(perm));
    settings++;
  endtask

  function automatic logic [FIELD_W-1:0] random_size();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return FIELD_W'($urandom_range(65535));
    return FIELD_W'($urandom_range(1, 5));
  endfunction

  function automatic logic [FIELD_W-1:0] random_stride();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return FIELD_W'($urandom_range(65535));
  endfunction

  // Half of the time a true permutation, otherwise any code, which brings in
  // repeated sources and sources beyond the dimensions in use.
  function automatic logic [PERM_REG_W-1:0] random_permutation();
    int                    order [MAX_DIMS];
    int                    j;
    int                    t;
    logic [PERM_REG_W-1:0] code;
    if ($urandom_range(1) == 0) return PERM_REG_W'($urandom_range(255));
    for (int i = 0; i < MAX_DIMS; i++) order[i] = i;
    for (int i = MAX_DIMS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    code = '0;
    for (int i = 0; i < MAX_DIMS; i++) code[PERM_W*i +: PERM_W] = PERM_W'(order[i]);
    return code;
  endfunction

  // Rewrites a random subset of the registers, now and then also a spare
  // index that the block must ignore.
  task cfg_random();
    logic [DATA_W-1:0] sizes;
    logic [DATA_W-1:0] istr;
    logic [DATA_W-1:0] ostr;
    int unsigned       nd_pick;
    for (int i = 0; i < MAX_DIMS; i++) begin
      sizes[FIELD_W*i +: FIELD_W] = random_size();
      istr[FIELD_W*i +: FIELD_W]  = random_stride();
      ostr[FIELD_W*i +: FIELD_W]  = random_stride();
    end
    // Mostly legal dimension counts, with zero and the clamped codes too.
    nd_pick = $urandom_range(9);
    if ($urandom_range(9) < 7) begin
      cfg_write(REG_NUM_DIMS, DATA_W'((nd_pick < 8) ? (nd_pick % MAX_DIMS) + 1 : nd_pick - 8 + 5));
    end
    if ($urandom_range(9) < 7) cfg_write(REG_NUM_DIMS, DATA_W'($urandom_range(7)));
    if ($urandom_range(9) < 8) cfg_write(REG_DIM_SIZES, sizes);
    if ($urandom_range(9) < 7) cfg_write(REG_IN_STRIDES, istr);
    if ($urandom_range(9) < 7) cfg_write(REG_OUT_STRIDES, ostr);
    if ($urandom_range(9) < 7) cfg_write(REG_PERMUTATION, DATA_W'(random_permutation()));
    if ($urandom_range(9) == 0) begin
      cfg_write(REG_SPARE_FIRST + REG_SEL_W'($urandom_range(REG_SPARE_SPAN - 1)),
                {$urandom, $urandom});
    end
    settings++;
  endtask

  initial begin
    int count;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.element <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset shape: one dimension of size one, so every element is the last
    // one and both offsets are zero.
    send_element('0);
    send_element('1);
    drain();

    // A dimension count of zero acts as one, and a size of zero as one.
    cfg_shape(NDIM_W'(0), '0, '1, '1, PERM_REG_W'(228));
    send_element(ELEM_W'(16'h5555));
    send_element(ELEM_W'(16'haaaa));
    drain();

    // Two dimensions whose output takes dimension 0 twice.
    cfg_shape(NDIM_W'(2), {16'd0, 16'd0, 16'd2, 16'd3}, {16'd0, 16'd0, 16'd6, 16'd2},
              {16'd0, 16'd0, 16'd100, 16'd1}, PERM_REG_W'(0));
    send_elements(6);
    drain();

    // Count above the maximum clamps to four; reversed order, largest strides.
    cfg_shape(NDIM_W'(7), {16'd2, 16'd2, 16'd1, 16'd2}, '1, '1, PERM_REG_W'(8'h1b));
    send_elements(8);
    drain();

    // Sources beyond the dimensions in use supply coordinate zero. The
    // tensor is left part way, at coordinate three of dimension 0.
    cfg_shape(NDIM_W'(2), {16'd0, 16'd0, 16'd3, 16'd5}, {16'd0, 16'd0, 16'd40, 16'd2},
              {16'd0, 16'd0, 16'd7, 16'd9}, PERM_REG_W'(8'hff));
    send_elements(3);
    drain();

    // Shrinking dimension 0 below the current coordinate: it is taken as
    // final and wraps on the next step. A spare register write goes unseen.
    cfg_write(REG_DIM_SIZES, {16'd0, 16'd0, 16'd3, 16'd2});
    cfg_write(REG_SPARE_FIRST, '1);
    send_elements(3);
    drain();

    // Random phases. Each rewrites part of the registers while idle, often
    // in the middle of a tensor, then streams a burst of elements. A few
    // phases in the middle run without any idle cycles.
    for (int phase = 0; random_sent < RANDOM_ELEMENTS; phase++) begin
      cfg_random();
      steady = (phase >= 6 && phase < 9);
      count = $urandom_range(8, 60);
      send_elements(count);
      random_sent += count;
      drain();
    end
    steady = 1'b0;

    // The pipeline is three deep; give it a little extra to show stray output.
    repeat (8) @(negedge clk);

    $display("Covered %0d element requests and %0d results over %0d register settings.",
             random_sent + 24, sb.results, settings);
    $display("Saw %0d tensor ends, %0d mismatches, in %0d cycles.", sb.tensor_ends,
             sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("tensor_permute_address_generator test passed");
    end else begin
      $display("tensor_permute_address_generator test failed");
    end
    $finish;
  end

endmodule
